FILE: design/trc_pkg.sv
// ----------------------------------------------------------------------------
// trc_pkg
// Shared types and constants of the textured tile rectangle clipper.
// ----------------------------------------------------------------------------
package trc_pkg;

  localparam int CW     = 24;
  localparam int SPW    = 25;
  localparam int PW     = 2 * SPW;
  localparam int QW     = 25;
  localparam int QSW    = QW + 1;
  localparam int RW     = PW + 2;
  localparam int DIV_LAT = QW + 1;
  localparam int TGW    = 16;
  localparam int OW     = 28;
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  typedef enum logic [2:0] {
    REG_CLIP_LEFT   = 3'd0,
    REG_CLIP_TOP    = 3'd1,
    REG_CLIP_RIGHT  = 3'd2,
    REG_CLIP_BOTTOM = 3'd3,
    REG_UI_SCALE    = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic signed [CW-1:0] clip_left;
    logic signed [CW-1:0] clip_top;
    logic signed [CW-1:0] clip_right;
    logic signed [CW-1:0] clip_bottom;
    logic        [3:0]    ui_scale;
  } cfg_t;

  typedef struct packed {
    logic signed [CW-1:0]  dl;
    logic signed [CW-1:0]  dt;
    logic signed [CW-1:0]  dr;
    logic signed [CW-1:0]  db;
    logic signed [CW-1:0]  sl;
    logic signed [CW-1:0]  st;
    logic signed [CW-1:0]  sr;
    logic signed [CW-1:0]  sb;
    logic        [TGW-1:0] tag;
  } geo_t;

  typedef struct packed {
    geo_t                 geo;
    logic signed [PW-1:0] pl;
    logic signed [PW-1:0] pr;
    logic signed [PW-1:0] pt;
    logic signed [PW-1:0] pb;
    logic [SPW-1:0]       dw;
    logic [SPW-1:0]       dh;
  } item_t;

endpackage

FILE: design/trc_front.sv
// ----------------------------------------------------------------------------
// trc_front
// Accepts tiles, rejects inverted ones and empty ones outside the window, clips
// the destination and forms the products for the source edge adjustment.
// ----------------------------------------------------------------------------
module trc_front import trc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 take_i,
  input  cfg_t                 cfg_i,
  input  geo_t                 geo_i,
  output logic                 vld_o,
  output item_t                item_o
);

  logic vld_q, vld_d;
  item_t item_q, item_d;
  logic inverted, in_win, cut_l, cut_r, cut_t, cut_b, empty, emit;
  logic signed [SPW-1:0] dw, dh, sw, sh, amt_l, amt_r, amt_t, amt_b;
  logic signed [CW-1:0] ndl, ndt, ndr, ndb;

  always_comb begin
    inverted = (geo_i.dl > geo_i.dr) || (geo_i.dt > geo_i.db);
    in_win   = (geo_i.dl >= cfg_i.clip_left) && (geo_i.dt >= cfg_i.clip_top) &&
               (geo_i.dr <= cfg_i.clip_right) && (geo_i.db <= cfg_i.clip_bottom);
    cut_l = !in_win && (geo_i.dl < cfg_i.clip_left);
    cut_r = !in_win && (geo_i.dr > cfg_i.clip_right);
    cut_t = !in_win && (geo_i.dt < cfg_i.clip_top);
    cut_b = !in_win && (geo_i.db > cfg_i.clip_bottom);
    dw    = SPW'(geo_i.dr) - SPW'(geo_i.dl);
    dh    = SPW'(geo_i.db) - SPW'(geo_i.dt);
    sw    = SPW'(geo_i.sr) - SPW'(geo_i.sl);
    sh    = SPW'(geo_i.sb) - SPW'(geo_i.st);
    amt_l = SPW'(cfg_i.clip_left) - SPW'(geo_i.dl);
    amt_r = SPW'(cfg_i.clip_right) - SPW'(geo_i.dr);
    amt_t = SPW'(cfg_i.clip_top) - SPW'(geo_i.dt);
    amt_b = SPW'(cfg_i.clip_bottom) - SPW'(geo_i.db);
    ndl   = cut_l ? cfg_i.clip_left : geo_i.dl;
    ndr   = cut_r ? cfg_i.clip_right : geo_i.dr;
    ndt   = cut_t ? cfg_i.clip_top : geo_i.dt;
    ndb   = cut_b ? cfg_i.clip_bottom : geo_i.db;
    empty = !((ndl < ndr) && (ndt < ndb));
    emit  = !inverted && (in_win || ((dw != '0) && (dh != '0) && !empty));

    item_d.geo    = geo_i;
    item_d.geo.dl = ndl;
    item_d.geo.dr = ndr;
    item_d.geo.dt = ndt;
    item_d.geo.db = ndb;
    item_d.pl = cut_l ? PW'(sw) * PW'(amt_l) : '0;
    item_d.pr = cut_r ? PW'(sw) * PW'(amt_r) : '0;
    item_d.pt = cut_t ? PW'(sh) * PW'(amt_t) : '0;
    item_d.pb = cut_b ? PW'(sh) * PW'(amt_b) : '0;
    item_d.dw = in_win ? SPW'(1) : dw;
    item_d.dh = in_win ? SPW'(1) : dh;
    vld_d = take_i && emit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

FILE: design/trc_queue.sv
// ----------------------------------------------------------------------------
// trc_queue
// Short queue between the classifying front and the clipping back.
// ----------------------------------------------------------------------------
module trc_queue import trc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  vld_o,
  output item_t item_o,
  output logic  almost_full_o
);

  item_t mem_q [QDEPTH];
  logic [QAW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QAW:0] cnt_q, cnt_d;
  logic pop, full;

  always_comb begin
    pop  = (cnt_q != '0);
    full = (cnt_q == (QAW+1)'(QDEPTH));
    wr_d = push_i ? wr_q + 1'b1 : wr_q;
    rd_d = pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (QAW+1)'(push_i) - (QAW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  assign vld_o         = pop;
  assign item_o        = mem_q[rd_q];
  assign almost_full_o = (cnt_q >= (QAW+1)'(QDEPTH - 1));

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(full && push_i && !pop)) else $error("queue overflow");
  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1)) else $error("count slip");

endmodule

FILE: design/trc_div.sv
// ----------------------------------------------------------------------------
// trc_div
// Pipelined signed divider, rounding to nearest with ties away from zero.
// One quotient bit is resolved in each stage after the input register.
// ----------------------------------------------------------------------------
module trc_div import trc_pkg::*; (
  input  logic                  clk_i,
  input  logic signed [PW-1:0]  num_i,
  input  logic [SPW-1:0]        den_i,
  output logic signed [QSW-1:0] quo_o
);

  logic [RW-1:0]  r_q [QW+1];
  logic [SPW:0]   d_q [QW+1];
  logic [QW-1:0]  q_q [QW+1];
  logic           neg_q [QW+1];
  logic [PW-1:0]  mag;

  assign mag = num_i[PW-1] ? PW'(-num_i) : PW'(num_i);

  always_ff @(posedge clk_i) begin
    r_q[0]   <= {1'b0, mag, 1'b0} + RW'(den_i);
    d_q[0]   <= {den_i, 1'b0};
    q_q[0]   <= '0;
    neg_q[0] <= num_i[PW-1];
  end

  for (genvar i = 1; i <= QW; i++) begin : g_stage
    logic [RW-1:0] sub;
    logic          fit;
    assign sub = RW'(d_q[i-1]) << (QW - i);
    assign fit = (r_q[i-1] >= sub);
    always_ff @(posedge clk_i) begin
      r_q[i]   <= fit ? r_q[i-1] - sub : r_q[i-1];
      d_q[i]   <= d_q[i-1];
      q_q[i]   <= q_q[i-1] | (fit ? (QW'(1) << (QW - i)) : '0);
      neg_q[i] <= neg_q[i-1];
    end
  end

  assign quo_o = neg_q[QW] ? -QSW'(q_q[QW]) : QSW'(q_q[QW]);

endmodule

FILE: design/trc_back.sv
// ----------------------------------------------------------------------------
// trc_back
// Adjusts the source edges by the divided clip amounts, scales the screen
// geometry and saturates the texture coordinates and spans.
// ----------------------------------------------------------------------------
module trc_back import trc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  vld_i,
  input  item_t                 item_i,
  input  logic [3:0]            ui_scale_i,
  output logic                  vld_o,
  output logic signed [OW-1:0]  x_o,
  output logic signed [OW-1:0]  y_o,
  output logic [OW-1:0]         w_o,
  output logic [OW-1:0]         h_o,
  output logic signed [CW-1:0]  u_o,
  output logic signed [CW-1:0]  v_o,
  output logic signed [SPW-1:0] us_o,
  output logic signed [SPW-1:0] vs_o,
  output logic [TGW-1:0]        tag_o
);

  logic signed [QSW-1:0] ql, qr, qt, qb;
  logic vld_sr_q [DIV_LAT];
  geo_t geo_sr_q [DIV_LAT];
  geo_t g;
  logic signed [QSW-1:0] nsl, nsr, nst, nsb;
  logic signed [QSW:0] spu, spv;
  logic signed [OW-1:0] sc;
  logic vld_q;
  logic signed [OW-1:0] x_q, y_q;
  logic [OW-1:0] w_q, h_q;
  logic signed [CW-1:0] u_q, v_q;
  logic signed [SPW-1:0] us_q, vs_q;
  logic [TGW-1:0] tag_q;

  trc_div u_div_l (.clk_i, .num_i(item_i.pl), .den_i(item_i.dw), .quo_o(ql));
  trc_div u_div_r (.clk_i, .num_i(item_i.pr), .den_i(item_i.dw), .quo_o(qr));
  trc_div u_div_t (.clk_i, .num_i(item_i.pt), .den_i(item_i.dh), .quo_o(qt));
  trc_div u_div_b (.clk_i, .num_i(item_i.pb), .den_i(item_i.dh), .quo_o(qb));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DIV_LAT; k++) begin
        vld_sr_q[k] <= 1'b0;
      end
      vld_q <= 1'b0;
    end else begin
      vld_sr_q[0] <= vld_i;
      for (int k = 1; k < DIV_LAT; k++) begin
        vld_sr_q[k] <= vld_sr_q[k-1];
      end
      vld_q <= vld_sr_q[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    geo_sr_q[0] <= item_i.geo;
    for (int k = 1; k < DIV_LAT; k++) begin
      geo_sr_q[k] <= geo_sr_q[k-1];
    end
  end

  always_comb begin
    g   = geo_sr_q[DIV_LAT-1];
    nsl = QSW'(g.sl) + ql;
    nsr = QSW'(g.sr) + qr;
    nst = QSW'(g.st) + qt;
    nsb = QSW'(g.sb) + qb;
    spu = (QSW+1)'(nsr) - (QSW+1)'(nsl);
    spv = (QSW+1)'(nsb) - (QSW+1)'(nst);
    sc  = OW'(signed'({1'b0, ui_scale_i}));
  end

  always_ff @(posedge clk_i) begin
    x_q <= OW'(g.dl) * sc;
    y_q <= OW'(g.dt) * sc;
    w_q <= OW'((OW'(g.dr) - OW'(g.dl)) * sc);
    h_q <= OW'((OW'(g.db) - OW'(g.dt)) * sc);
    priority if (nsl > QSW'(8388607)) u_q <= 24'sh7FFFFF;
    else if (nsl < -QSW'(8388608)) u_q <= 24'sh800000;
    else u_q <= CW'(nsl);
    priority if (nst > QSW'(8388607)) v_q <= 24'sh7FFFFF;
    else if (nst < -QSW'(8388608)) v_q <= 24'sh800000;
    else v_q <= CW'(nst);
    priority if (spu > (QSW+1)'(16777215)) us_q <= 25'sh0FFFFFF;
    else if (spu < -(QSW+1)'(16777216)) us_q <= 25'sh1000000;
    else us_q <= SPW'(spu);
    priority if (spv > (QSW+1)'(16777215)) vs_q <= 25'sh0FFFFFF;
    else if (spv < -(QSW+1)'(16777216)) vs_q <= 25'sh1000000;
    else vs_q <= SPW'(spv);
    tag_q <= g.tag;
  end

  assign vld_o = vld_q;
  assign x_o   = x_q;
  assign y_o   = y_q;
  assign w_o   = w_q;
  assign h_o   = h_q;
  assign u_o   = u_q;
  assign v_o   = v_q;
  assign us_o  = us_q;
  assign vs_o  = vs_q;
  assign tag_o = tag_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> $past(vld_i, DIV_LAT + 1)) else $error("result without item");

endmodule

FILE: design/textured_tile_rect_clipper.sv
// ----------------------------------------------------------------------------
// textured_tile_rect_clipper
// Clips a textured tile against the scissor window and scales the result.
// ----------------------------------------------------------------------------
// The result strobe follows the accepting edge through the front register, the
// queue, the divider pipeline and the back's output register.
// Throughput is one tile per cycle; busy stays low since the back drains the
// queue every cycle and the receiver cannot stall.
// Reset clears the valid pipeline and the queue and loads the register
// defaults: a window from zero to the largest coordinate and a scale of one.
module textured_tile_rect_clipper import trc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [4:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  start,
  output logic                  busy,
  input  logic signed [23:0]    dest_left_i,
  input  logic signed [23:0]    dest_top_i,
  input  logic signed [23:0]    dest_right_i,
  input  logic signed [23:0]    dest_bottom_i,
  input  logic signed [23:0]    src_left_i,
  input  logic signed [23:0]    src_top_i,
  input  logic signed [23:0]    src_right_i,
  input  logic signed [23:0]    src_bottom_i,
  input  logic [15:0]           tile_tag_i,
  output logic                  out_valid_o,
  output logic signed [27:0]    out_x_o,
  output logic signed [27:0]    out_y_o,
  output logic [27:0]           out_width_o,
  output logic [27:0]           out_height_o,
  output logic signed [23:0]    out_u_o,
  output logic signed [23:0]    out_v_o,
  output logic signed [24:0]    out_u_span_o,
  output logic signed [24:0]    out_v_span_o,
  output logic [15:0]           out_tag_o
);

  cfg_t cfg_q;
  geo_t geo_in;
  item_t f_item, q_item;
  logic f_vld, q_vld, almost_full, wr_en;
  reg_idx_e idx;

  assign idx   = reg_idx_e'(paddr[4:2]);
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.clip_left   <= '0;
      cfg_q.clip_top    <= '0;
      cfg_q.clip_right  <= 24'sh7FFFFF;
      cfg_q.clip_bottom <= 24'sh7FFFFF;
      cfg_q.ui_scale    <= 4'd1;
    end else if (wr_en) begin
      unique case (idx)
        REG_CLIP_LEFT:   cfg_q.clip_left   <= pwdata[23:0];
        REG_CLIP_TOP:    cfg_q.clip_top    <= pwdata[23:0];
        REG_CLIP_RIGHT:  cfg_q.clip_right  <= pwdata[23:0];
        REG_CLIP_BOTTOM: cfg_q.clip_bottom <= pwdata[23:0];
        REG_UI_SCALE:    cfg_q.ui_scale    <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CLIP_LEFT:   prdata = 32'(unsigned'(cfg_q.clip_left));
      REG_CLIP_TOP:    prdata = 32'(unsigned'(cfg_q.clip_top));
      REG_CLIP_RIGHT:  prdata = 32'(unsigned'(cfg_q.clip_right));
      REG_CLIP_BOTTOM: prdata = 32'(unsigned'(cfg_q.clip_bottom));
      REG_UI_SCALE:    prdata = 32'(cfg_q.ui_scale);
      default:         prdata = '0;
    endcase
  end

  assign pready = 1'b1;
  assign busy   = almost_full;

  always_comb begin
    geo_in.dl  = dest_left_i;
    geo_in.dt  = dest_top_i;
    geo_in.dr  = dest_right_i;
    geo_in.db  = dest_bottom_i;
    geo_in.sl  = src_left_i;
    geo_in.st  = src_top_i;
    geo_in.sr  = src_right_i;
    geo_in.sb  = src_bottom_i;
    geo_in.tag = tile_tag_i;
  end

  trc_front u_front (
    .clk_i, .rst_ni, .take_i(start && !busy), .cfg_i(cfg_q), .geo_i(geo_in),
    .vld_o(f_vld), .item_o(f_item)
  );

  trc_queue u_queue (
    .clk_i, .rst_ni, .push_i(f_vld), .item_i(f_item),
    .vld_o(q_vld), .item_o(q_item), .almost_full_o(almost_full)
  );

  trc_back u_back (
    .clk_i, .rst_ni, .vld_i(q_vld), .item_i(q_item), .ui_scale_i(cfg_q.ui_scale),
    .vld_o(out_valid_o), .x_o(out_x_o), .y_o(out_y_o), .w_o(out_width_o),
    .h_o(out_height_o), .u_o(out_u_o), .v_o(out_v_o), .us_o(out_u_span_o),
    .vs_o(out_v_span_o), .tag_o(out_tag_o)
  );

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy) else $error("queue backed up");

endmodule
